// ===== hdl/mtep_pkg.sv =====
package mtep_pkg;

	// Parser phase, one-hot
	typedef enum logic [9:0] {
		PH_DELTA    = 10'b00_0000_0001,
		PH_STATUS   = 10'b00_0000_0010,
		PH_DATA1    = 10'b00_0000_0100,
		PH_DATA2    = 10'b00_0000_1000,
		PH_SYSLEN   = 10'b00_0001_0000,
		PH_SYSBODY  = 10'b00_0010_0000,
		PH_METATYPE = 10'b00_0100_0000,
		PH_METALEN  = 10'b00_1000_0000,
		PH_METABODY = 10'b01_0000_0000,
		PH_ENDED    = 10'b10_0000_0000
	} phase_t;

	// Event class handed from the front to the back
	typedef enum logic [2:0] {
		CLS_CHAN1 = 3'd0,
		CLS_CHAN2 = 3'd1,
		CLS_END   = 3'd2,
		CLS_TEMPO = 3'd3,
		CLS_BAD   = 3'd4
	} evt_class_t;

	// Result kinds on the output channel
	localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
	localparam logic [2:0] KIND_OTHER    = 3'd2;
	localparam logic [2:0] KIND_END      = 3'd3;
	localparam logic [2:0] KIND_TEMPO    = 3'd4;
	localparam logic [2:0] KIND_BAD      = 3'd5;

	// Status byte codes
	localparam logic [7:0] ST_SYSEX      = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
	localparam logic [7:0] ST_META       = 8'hFF;
	localparam logic [3:0] HI_SYSTEM     = 4'hF;
	localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
	localparam logic [3:0] HI_NOTE_ON    = 4'h9;
	localparam logic [3:0] HI_PROG       = 4'hC;
	localparam logic [3:0] HI_CHAN_PRESS = 4'hD;

	// Meta event types
	localparam logic [7:0] META_END   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		evt_class_t  cls;
		logic [7:0]  status;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [31:0] delta;
		logic [23:0] tempo;
	} evt_rec_t;

endpackage

// ===== hdl/mtep_byte_if.sv =====
interface mtep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       track_start;

	modport source (output valid, output data_byte, output track_start, input ready);
	modport sink (input valid, input data_byte, input track_start, output ready);
endinterface

// ===== hdl/mtep_event_if.sv =====
interface mtep_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [7:0]  key;
	logic [7:0]  velocity;
	logic [31:0] delta_ticks;
	logic [23:0] tempo_value;

	modport source (output valid, output event_kind, output channel, output key,
		output velocity, output delta_ticks, output tempo_value, input ready);
	modport sink (input valid, input event_kind, input channel, input key,
		input velocity, input delta_ticks, input tempo_value, output ready);
endinterface

// ===== hdl/mtep_front.sv =====
module mtep_front
	import mtep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mtep_byte_if.sink track,
	output logic      push_valid,
	output evt_rec_t  push_data,
	input  logic      push_ready
);

	phase_t      phase_q, e_phase, phase_n;
	logic [31:0] acc_q, e_acc, acc_n;
	logic [31:0] held_q, e_held, held_n;
	logic [7:0]  rs_q, e_rs, rs_n;
	logic [7:0]  cs_q, e_cs, cs_n;
	logic [7:0]  fd_q, e_fd, fd_n;
	logic [7:0]  mt_q, e_mt, mt_n;
	logic [31:0] bl_q, e_bl, bl_n;
	logic [1:0]  ti_q, e_ti, ti_n;
	logic [23:0] tempo_q, tempo_n;

	logic [7:0]  b;
	logic        accept;
	logic [31:0] vlq;
	logic        vlq_done;
	logic [31:0] bl_dec;
	logic [31:0] acc_body;
	logic        do_take;
	logic [7:0]  take_status;
	logic        do_finish;
	logic [23:0] fin_val;
	logic        emit;
	evt_rec_t    rec;

	assign b           = track.data_byte;
	assign track.ready = push_ready;
	assign accept      = track.valid && push_ready;

	// Start of track clears the per-track state before the byte is used
	always_comb begin
		if (track.track_start) begin
			e_phase = PH_DELTA;
			e_acc   = '0;
			e_held  = '0;
			e_rs    = '0;
			e_cs    = '0;
			e_fd    = '0;
			e_mt    = '0;
			e_bl    = '0;
			e_ti    = '0;
		end else begin
			e_phase = phase_q;
			e_acc   = acc_q;
			e_held  = held_q;
			e_rs    = rs_q;
			e_cs    = cs_q;
			e_fd    = fd_q;
			e_mt    = mt_q;
			e_bl    = bl_q;
			e_ti    = ti_q;
		end
	end

	assign vlq      = {e_acc[24:0], b[6:0]};
	assign vlq_done = !b[7];
	assign bl_dec   = e_bl - 32'd1;

	// Fold a tempo body byte into the accumulator, high byte first
	always_comb begin
		acc_body = e_acc;
		if (e_mt == META_TEMPO) begin
			case (e_ti)
				2'd0:    acc_body = e_acc | {8'd0, b, 16'd0};
				2'd1:    acc_body = e_acc | {16'd0, b, 8'd0};
				2'd2:    acc_body = e_acc | {24'd0, b};
				default: acc_body = e_acc;
			endcase
		end
	end

	// Per-byte parse step
	always_comb begin
		phase_n     = e_phase;
		acc_n       = e_acc;
		held_n      = e_held;
		rs_n        = e_rs;
		cs_n        = e_cs;
		fd_n        = e_fd;
		mt_n        = e_mt;
		bl_n        = e_bl;
		ti_n        = e_ti;
		tempo_n     = tempo_q;
		do_take     = 1'b0;
		take_status = e_cs;
		do_finish   = 1'b0;
		fin_val     = '0;
		emit        = 1'b0;
		rec.cls     = CLS_BAD;
		rec.status  = '0;
		rec.d1      = '0;
		rec.d2      = '0;
		rec.delta   = e_held;
		rec.tempo   = '0;

		case (e_phase)
			PH_DELTA: begin
				acc_n = vlq;
				if (vlq_done) begin
					held_n  = vlq;
					acc_n   = '0;
					phase_n = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (!b[7]) begin
					if (e_rs == 8'd0) begin
						emit    = 1'b1;
						rec.cls = CLS_BAD;
						held_n  = {24'd0, b};
						acc_n   = '0;
					end else begin
						cs_n        = e_rs;
						do_take     = 1'b1;
						take_status = e_rs;
					end
				end else begin
					cs_n = b;
					if (b[7:4] != HI_SYSTEM) begin
						rs_n    = b;
						phase_n = PH_DATA1;
					end else begin
						rs_n  = '0;
						acc_n = '0;
						if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
							phase_n = PH_SYSLEN;
						end else if (b == ST_META) begin
							phase_n = PH_METATYPE;
						end else begin
							phase_n = PH_DELTA;
						end
					end
				end
			end
			PH_DATA1: begin
				do_take     = 1'b1;
				take_status = e_cs;
			end
			PH_DATA2: begin
				phase_n    = PH_DELTA;
				emit       = 1'b1;
				rec.cls    = CLS_CHAN2;
				rec.status = e_cs;
				rec.d1     = e_fd;
				rec.d2     = b;
			end
			PH_SYSLEN: begin
				acc_n = vlq;
				if (vlq_done) begin
					bl_n    = vlq;
					acc_n   = '0;
					phase_n = (vlq != 32'd0) ? PH_SYSBODY : PH_DELTA;
				end
			end
			PH_SYSBODY: begin
				bl_n = bl_dec;
				if (bl_dec == 32'd0) begin
					phase_n = PH_DELTA;
				end
			end
			PH_METATYPE: begin
				mt_n    = b;
				ti_n    = '0;
				acc_n   = '0;
				phase_n = PH_METALEN;
			end
			PH_METALEN: begin
				acc_n = vlq;
				if (vlq_done) begin
					bl_n  = vlq;
					acc_n = '0;
					if (vlq == 32'd0) begin
						do_finish = 1'b1;
						fin_val   = '0;
					end else begin
						phase_n = PH_METABODY;
					end
				end
			end
			PH_METABODY: begin
				acc_n = acc_body;
				if (e_mt == META_TEMPO && e_ti != 2'd3) begin
					ti_n = e_ti + 2'd1;
				end
				bl_n = bl_dec;
				if (bl_dec == 32'd0) begin
					do_finish = 1'b1;
					fin_val   = acc_body[23:0];
				end
			end
			PH_ENDED: begin
				phase_n = PH_ENDED;
			end
			default: begin
				phase_n = PH_DELTA;
			end
		endcase

		// First data byte of a channel message
		if (do_take) begin
			fd_n = b;
			if (take_status[7:4] == HI_PROG || take_status[7:4] == HI_CHAN_PRESS) begin
				phase_n    = PH_DELTA;
				emit       = 1'b1;
				rec.cls    = CLS_CHAN1;
				rec.status = take_status;
				rec.d1     = b;
			end else begin
				phase_n = PH_DATA2;
			end
		end

		// End of a meta event
		if (do_finish) begin
			acc_n = '0;
			bl_n  = '0;
			if (e_mt == META_END) begin
				phase_n = PH_ENDED;
				emit    = 1'b1;
				rec.cls = CLS_END;
			end else begin
				phase_n = PH_DELTA;
				if (e_mt == META_TEMPO && tempo_q == 24'd0 && fin_val != 24'd0) begin
					tempo_n   = fin_val;
					emit      = 1'b1;
					rec.cls   = CLS_TEMPO;
					rec.tempo = fin_val;
				end
			end
		end
	end

	assign push_valid = accept && emit;
	assign push_data  = rec;

	// Advance parser state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			acc_q   <= '0;
			held_q  <= '0;
			rs_q    <= '0;
			cs_q    <= '0;
			fd_q    <= '0;
			mt_q    <= '0;
			bl_q    <= '0;
			ti_q    <= '0;
			tempo_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			held_q  <= held_n;
			rs_q    <= rs_n;
			cs_q    <= cs_n;
			fd_q    <= fd_n;
			mt_q    <= mt_n;
			bl_q    <= bl_n;
			ti_q    <= ti_n;
			tempo_q <= tempo_n;
		end
	end

endmodule

// ===== hdl/mtep_queue.sv =====
module mtep_queue
	import mtep_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  evt_rec_t push_data,
	output logic     push_ready,
	output logic     pop_valid,
	output evt_rec_t pop_data,
	input  logic     pop_ready
);

	evt_rec_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign push_ready = (cnt_q != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store pushed records
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== hdl/mtep_back.sv =====
module mtep_back
	import mtep_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  evt_rec_t       pop_data,
	output logic           pop_ready,
	mtep_event_if.source   evt
);

	logic        valid_q;
	logic [2:0]  kind_q, kind_n;
	logic [3:0]  chan_q, chan_n;
	logic [7:0]  key_q, key_n;
	logic [7:0]  vel_q, vel_n;
	logic [31:0] delta_q;
	logic [23:0] tempo_q, tempo_n;
	logic [3:0]  hi;

	assign pop_ready = !valid_q || evt.ready;
	assign hi        = pop_data.status[7:4];

	// Turn a record class into result fields
	always_comb begin
		kind_n  = KIND_BAD;
		chan_n  = '0;
		key_n   = '0;
		vel_n   = '0;
		tempo_n = '0;
		case (pop_data.cls)
			CLS_CHAN1: begin
				kind_n = KIND_OTHER;
				chan_n = pop_data.status[3:0];
				key_n  = pop_data.d1;
			end
			CLS_CHAN2: begin
				chan_n = pop_data.status[3:0];
				key_n  = pop_data.d1;
				vel_n  = pop_data.d2;
				if (hi == HI_NOTE_OFF || (hi == HI_NOTE_ON && pop_data.d2 == 8'd0)) begin
					kind_n = KIND_NOTE_OFF;
				end else if (hi == HI_NOTE_ON) begin
					kind_n = KIND_NOTE_ON;
				end else begin
					kind_n = KIND_OTHER;
				end
			end
			CLS_END: begin
				kind_n = KIND_END;
			end
			CLS_TEMPO: begin
				kind_n  = KIND_TEMPO;
				tempo_n = pop_data.tempo;
			end
			CLS_BAD: begin
				kind_n = KIND_BAD;
			end
			default: begin
				kind_n = KIND_BAD;
			end
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	// Output payload, loaded when the register is free
	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			kind_q  <= kind_n;
			chan_q  <= chan_n;
			key_q   <= key_n;
			vel_q   <= vel_n;
			delta_q <= pop_data.delta;
			tempo_q <= tempo_n;
		end
	end

	assign evt.valid       = valid_q;
	assign evt.event_kind  = kind_q;
	assign evt.channel     = chan_q;
	assign evt.key         = key_q;
	assign evt.velocity    = vel_q;
	assign evt.delta_ticks = delta_q;
	assign evt.tempo_value = tempo_q;

endmodule

// ===== hdl/midi_track_event_parser_core.sv =====
// Throughput: one track byte per cycle; the parser takes a byte in every cycle the queue has room.
// An event's record is queued at the edge that accepts its last byte and loads into the
// output register once that register is free; the output register presents the result beat.
// Four events wait in the queue and one in the output register before the input stalls.
// Reset (arst_n low, asynchronous): parser waits for a delta, running status, tempo capture,
// queue pointers and output valid are cleared.
module midi_track_event_parser_core
	import mtep_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mtep_byte_if.sink    track,
	mtep_event_if.source evt
);

	logic     push_valid, push_ready;
	evt_rec_t push_data;
	logic     pop_valid, pop_ready;
	evt_rec_t pop_data;

	mtep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.track      (track),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	mtep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	mtep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.evt       (evt)
	);

endmodule
